FILE: sv/ttr_pkg.sv
// shared types, widths and constants for the triggered transient recorder
`default_nettype none

package ttr_pkg;

    localparam int SAMPLE_W     = 10;
    localparam int REG_W        = 10;
    localparam int ADDR_W       = 12;
    localparam int PHASE_W      = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 24;

    localparam int AVG_LOG2_DEF      = 5;
    localparam int CAPTURE_DEPTH_DEF = 4096;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON_AT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD      = 2'd2;

    localparam logic [REG_W-1:0] THRESHOLD_RST    = 10'd56;
    localparam logic [REG_W-1:0] BLINK_ON_AT_RST  = 10'd300;
    localparam logic [REG_W-1:0] BLINK_PERIOD_RST = 10'd600;

    // phase codes reported with each result
    localparam logic [PHASE_W-1:0] PH_BASE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ARMED = 2'd1;
    localparam logic [PHASE_W-1:0] PH_REC   = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DONE  = 2'd3;

    typedef enum logic [3:0] {
        MODE_BASE  = 4'b0001,
        MODE_ARMED = 4'b0010,
        MODE_REC   = 4'b0100,
        MODE_DONE  = 4'b1000
    } mode_t;

    typedef struct packed {
        logic                button_pressed;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [REG_W-1:0] trigger_threshold;
        logic [REG_W-1:0] blink_on_at;
        logic [REG_W-1:0] blink_period;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0]  phase;
        logic                last_write;
        logic [SAMPLE_W-1:0] write_data;
        logic [ADDR_W-1:0]   write_address;
        logic                write_valid;
        logic                led;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/ttr_in_stage.sv
// input register stage with stream handshake
`default_nettype none

module ttr_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire ttr_pkg::item_t s_item,
    input  wire logic          take,
    output logic               item_valid,
    output ttr_pkg::item_t     item
);
    import ttr_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

FILE: sv/ttr_core.sv
// recorder state and the per-word step logic
`default_nettype none

module ttr_core #(
    parameter int AVG_LOG2      = ttr_pkg::AVG_LOG2_DEF,
    parameter int CAPTURE_DEPTH = ttr_pkg::CAPTURE_DEPTH_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            fire,
    input  wire ttr_pkg::item_t  item,
    input  wire ttr_pkg::cfg_t   cfg,
    output ttr_pkg::result_t     result
);
    import ttr_pkg::*;

    localparam int SUM_W = SAMPLE_W + AVG_LOG2;
    localparam int CAP_W = $clog2(CAPTURE_DEPTH);
    localparam logic [CAP_W-1:0] CAP_LAST = CAP_W'(CAPTURE_DEPTH - 1);

    mode_t               mode_reg, mode_next;
    logic [AVG_LOG2-1:0] win_idx_reg, win_idx_next;
    logic [SUM_W-1:0]    win_sum_reg, win_sum_next;
    logic [SAMPLE_W-1:0] baseline_reg, baseline_next;
    logic [REG_W-1:0]    blink_reg, blink_next;
    logic                led_reg, led_next;
    logic [CAP_W-1:0]    cap_idx_reg, cap_idx_next;

    logic                win_last;
    logic [SUM_W-1:0]    sum_add;
    logic [SAMPLE_W-1:0] avg;
    logic [SAMPLE_W-1:0] dev;
    logic [REG_W-1:0]    blink_inc;
    logic                rec_now;
    logic [CAP_W-1:0]    cap_cur;

    assign win_last  = (win_idx_reg == {AVG_LOG2{1'b1}});
    assign sum_add   = win_sum_reg + SUM_W'(item.sample);
    assign avg       = sum_add[SUM_W-1:AVG_LOG2];
    assign dev       = (avg >= baseline_reg) ? (avg - baseline_reg) : (baseline_reg - avg);
    assign blink_inc = blink_reg + REG_W'(1);

    always_comb begin
        mode_next     = mode_reg;
        win_idx_next  = win_idx_reg;
        win_sum_next  = win_sum_reg;
        baseline_next = baseline_reg;
        blink_next    = blink_reg;
        led_next      = led_reg;
        cap_idx_next  = cap_idx_reg;
        rec_now       = 1'b0;
        cap_cur       = cap_idx_reg;
        result        = '0;

        case (mode_reg)
            MODE_BASE: begin
                result.phase = PH_BASE;
                if (win_last) begin
                    baseline_next = avg;
                    win_sum_next  = '0;
                    win_idx_next  = '0;
                    blink_next    = '0;
                    led_next      = 1'b1;
                    mode_next     = MODE_ARMED;
                end else begin
                    win_sum_next = sum_add;
                    win_idx_next = win_idx_reg + AVG_LOG2'(1);
                end
            end
            MODE_ARMED: begin
                result.phase = PH_ARMED;
                if (win_idx_reg == '0 && item.button_pressed) begin
                    // button held at window start: this word is the first capture write
                    rec_now      = 1'b1;
                    cap_cur      = '0;
                    win_sum_next = '0;
                    win_idx_next = '0;
                    led_next     = 1'b1;
                    mode_next    = MODE_REC;
                end else begin
                    if (win_idx_reg == '0) begin
                        blink_next = blink_inc;
                        if (blink_inc == cfg.blink_on_at) begin
                            led_next = 1'b1;
                        end
                        if (blink_inc == cfg.blink_period) begin
                            led_next   = 1'b0;
                            blink_next = '0;
                        end
                    end
                    if (win_last) begin
                        win_sum_next = '0;
                        win_idx_next = '0;
                        if (dev >= cfg.trigger_threshold) begin
                            cap_idx_next = '0;
                            led_next     = 1'b1;
                            mode_next    = MODE_REC;
                        end
                    end else begin
                        win_sum_next = sum_add;
                        win_idx_next = win_idx_reg + AVG_LOG2'(1);
                    end
                end
            end
            MODE_REC: begin
                rec_now = 1'b1;
            end
            MODE_DONE: begin
                result.phase = PH_DONE;
            end
            default: begin
                mode_next = MODE_DONE;
            end
        endcase

        if (rec_now) begin
            result.phase         = PH_REC;
            result.write_valid   = 1'b1;
            result.write_address = ADDR_W'(cap_cur);
            result.write_data    = item.sample;
            cap_idx_next         = cap_cur + CAP_W'(1);
            if (cap_cur == CAP_LAST) begin
                result.last_write = 1'b1;
                led_next          = 1'b0;
                mode_next         = MODE_DONE;
            end
        end

        result.led = led_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_BASE;
            win_idx_reg  <= '0;
            win_sum_reg  <= '0;
            baseline_reg <= '0;
            blink_reg    <= '0;
            led_reg      <= 1'b0;
            cap_idx_reg  <= '0;
        end else if (fire) begin
            mode_reg     <= mode_next;
            win_idx_reg  <= win_idx_next;
            win_sum_reg  <= win_sum_next;
            baseline_reg <= baseline_next;
            blink_reg    <= blink_next;
            led_reg      <= led_next;
            cap_idx_reg  <= cap_idx_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/ttr_out_stage.sv
// result register stage with stream handshake
`default_nettype none

module ttr_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             res_valid,
    input  wire ttr_pkg::result_t res,
    output logic                  res_ready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output ttr_pkg::result_t      m_res
);
    import ttr_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign res_ready  = !valid_reg || m_tready;
    assign valid_next = res_ready ? res_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

`default_nettype wire

FILE: sv/triggered_transient_recorder.sv
// top level of the triggered transient recorder
`default_nettype none

// Triggered transient recorder. Each input word carries one 10-bit converter
// sample and the trigger button level; each accepted word yields exactly one
// result word. The first 2^AVG_LOG2 samples are averaged into a baseline, after
// which the block is armed: it averages windows of the same length and starts a
// capture when a window's distance from the baseline reaches trigger_threshold
// (capture begins with the following word), or at once when the button is held
// on the first word of a window. While armed the led blinks from a counter that
// steps once per window. A capture writes CAPTURE_DEPTH samples with word
// addresses (modulo 4096), flags the final one with m_tlast, turns the led off
// and then the block stays in the done phase until reset. One word per clock is
// sustained in both directions while m_tready is held high; a result passes
// through the input register, one pass of accumulate, compare and counter
// logic, and the result register. Configuration writes are taken any
// time but are meant for idle periods.
module triggered_transient_recorder #(
    parameter int AVG_LOG2      = ttr_pkg::AVG_LOG2_DEF,
    parameter int CAPTURE_DEPTH = ttr_pkg::CAPTURE_DEPTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // sample stream in
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // sample [9:0], button_pressed [10], zero pad [15:11]
    input  wire logic [ttr_pkg::IN_TDATA_W-1:0]   s_tdata,
    // result stream out
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // led [0], write_valid [1], write_address [13:2], write_data [23:14]
    output logic [ttr_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // last_write
    output logic                                  m_tlast,
    // phase [1:0]
    output logic [ttr_pkg::PHASE_W-1:0]           m_tuser,
    // register write port
    input  wire logic                             cfg_wr_en,
    input  wire logic [ttr_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [ttr_pkg::REG_W-1:0]        cfg_wdata
);
    import ttr_pkg::*;

    // configuration registers
    cfg_t    cfg_reg, cfg_next;

    // pipeline hand-off
    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    res_ready;
    logic    advance;
    result_t res;
    result_t m_res;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_TRIGGER_THRESHOLD: cfg_next.trigger_threshold = cfg_wdata;
                CFG_BLINK_ON_AT:       cfg_next.blink_on_at       = cfg_wdata;
                CFG_BLINK_PERIOD:      cfg_next.blink_period      = cfg_wdata;
                default:               cfg_next = cfg_reg; // unused index
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_threshold <= THRESHOLD_RST;
            cfg_reg.blink_on_at       <= BLINK_ON_AT_RST;
            cfg_reg.blink_period      <= BLINK_PERIOD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // unpack the incoming word
    assign s_item.sample         = s_tdata[SAMPLE_W-1:0];
    assign s_item.button_pressed = s_tdata[SAMPLE_W];

    // a word moves from the input register through the step logic into the
    // result register whenever the result register can take it
    assign advance = item_valid && res_ready;

    ttr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ttr_core #(
        .AVG_LOG2      (AVG_LOG2),
        .CAPTURE_DEPTH (CAPTURE_DEPTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (item),
        .cfg     (cfg_reg),
        .result  (res)
    );

    ttr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (item_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    // pack the result word
    assign m_tdata = {m_res.write_data, m_res.write_address, m_res.write_valid, m_res.led};
    assign m_tlast = m_res.last_write;
    assign m_tuser = m_res.phase;

endmodule

`default_nettype wire

FILE: sv/ttr_checker.sv
// port-level checks for the triggered transient recorder, bound to the top level
`default_nettype none

module ttr_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [ttr_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input wire logic                             m_tlast,
    input wire logic [ttr_pkg::PHASE_W-1:0]      m_tuser
);
    import ttr_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result word changed while stalled");

    // no write means empty write fields
    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> m_tdata[23:2] == '0 && !m_tlast)
        else $error("write fields set without write_valid");

    // writes happen only while recording
    a_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1] || m_tlast) |-> m_tuser == PH_REC && m_tdata[1])
        else $error("write outside recording phase");

    // done phase keeps the led off and writes nothing
    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == PH_DONE |-> m_tdata[1:0] == 2'b00)
        else $error("activity in done phase");

endmodule

bind triggered_transient_recorder ttr_checker u_ttr_checker (.*);

`default_nettype wire

FILE: tb/recorder_checker.sv
// result predictor and scoreboard for the triggered transient recorder
module recorder_checker #(
    parameter int AVG_LOG2      = ttr_pkg::AVG_LOG2_DEF,
    parameter int CAPTURE_DEPTH = ttr_pkg::CAPTURE_DEPTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    // sample [9:0], button_pressed [10], zero pad [15:11]
    input  wire logic [ttr_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    // led [0], write_valid [1], write_address [13:2], write_data [23:14]
    input  wire logic [ttr_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                            m_tlast,
    // phase [1:0]
    input  wire logic [ttr_pkg::PHASE_W-1:0]     m_tuser,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ttr_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [ttr_pkg::REG_W-1:0]       cfg_wdata,
    output int                                   mismatches,
    output int                                   words_pending
);
    import ttr_pkg::*;

    localparam int WINDOW_LEN = 1 << AVG_LOG2;
    localparam int MAX_REPORTS = 10;

    // register copies
    logic [REG_W-1:0]    threshold_q;
    logic [REG_W-1:0]    blink_on_q;
    logic [REG_W-1:0]    blink_period_q;

    // recorder state
    logic [PHASE_W-1:0]  phase_q;
    int                  win_pos;
    int                  win_sum;
    logic [SAMPLE_W-1:0] baseline_q;
    logic [REG_W-1:0]    blink_q;
    logic                led_q;
    int                  capture_pos;

    result_t             recorder_results_due[$];
    int                  results_seen;

    // one word in, one result out; updates the state copy
    function automatic result_t advance_recorder(input item_t word_in);
        result_t             res;
        logic [PHASE_W-1:0]  handled;
        logic                grab_now;
        int                  shifted;
        logic [SAMPLE_W-1:0] avg;
        logic [SAMPLE_W-1:0] dev;
        res      = '0;
        handled  = phase_q;
        grab_now = 1'b0;
        if (handled == PH_BASE) begin
            win_sum = win_sum + int'(word_in.sample);
            win_pos = win_pos + 1;
            if (win_pos >= WINDOW_LEN) begin
                shifted    = win_sum >> AVG_LOG2;
                baseline_q = shifted[SAMPLE_W-1:0];
                win_sum    = 0;
                win_pos    = 0;
                blink_q    = '0;
                led_q      = 1'b1;
                phase_q    = PH_ARMED;
            end
        end else if (handled == PH_ARMED) begin
            // button and blink only matter on the first word of a window
            if (win_pos == 0) begin
                if (word_in.button_pressed) begin
                    grab_now = 1'b1;
                end else begin
                    blink_q = blink_q + 1'b1;
                    if (blink_q == blink_on_q) led_q = 1'b1;
                    if (blink_q == blink_period_q) begin
                        led_q   = 1'b0;
                        blink_q = '0;
                    end
                end
            end
            if (grab_now) begin
                phase_q     = PH_REC;
                capture_pos = 0;
                led_q       = 1'b1;
                win_sum     = 0;
                win_pos     = 0;
                handled     = PH_REC;
            end else begin
                win_sum = win_sum + int'(word_in.sample);
                win_pos = win_pos + 1;
                if (win_pos >= WINDOW_LEN) begin
                    shifted = win_sum >> AVG_LOG2;
                    avg     = shifted[SAMPLE_W-1:0];
                    dev     = (avg >= baseline_q) ? avg - baseline_q : baseline_q - avg;
                    win_sum = 0;
                    win_pos = 0;
                    // capture starts with the next word
                    if (dev >= threshold_q) begin
                        phase_q     = PH_REC;
                        capture_pos = 0;
                        led_q       = 1'b1;
                    end
                end
            end
        end
        if (handled == PH_REC) begin
            res.write_valid   = 1'b1;
            res.write_address = capture_pos[ADDR_W-1:0];
            res.write_data    = word_in.sample;
            capture_pos       = capture_pos + 1;
            if (capture_pos >= CAPTURE_DEPTH) begin
                res.last_write = 1'b1;
                led_q          = 1'b0;
                phase_q        = PH_DONE;
            end
        end
        res.led   = led_q;
        res.phase = handled;
        return res;
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            threshold_q    = THRESHOLD_RST;
            blink_on_q     = BLINK_ON_AT_RST;
            blink_period_q = BLINK_PERIOD_RST;
            phase_q        = PH_BASE;
            win_pos        = 0;
            win_sum        = 0;
            baseline_q     = '0;
            blink_q        = '0;
            led_q          = 1'b0;
            capture_pos    = 0;
            results_seen   = 0;
            mismatches     = 0;
            recorder_results_due.delete();
        end else begin
            // compare first so a stray result cannot borrow this edge's prediction
            if (m_tvalid && m_tready) begin
                got.led           = m_tdata[0];
                got.write_valid   = m_tdata[1];
                got.write_address = m_tdata[13:2];
                got.write_data    = m_tdata[23:14];
                got.last_write    = m_tlast;
                got.phase         = m_tuser;
                if (recorder_results_due.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d arrived with nothing outstanding: %p",
                                 results_seen, got);
                end else begin
                    want = recorder_results_due.pop_front();
                    if (got !== want) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_REPORTS)
                            $display("result %0d: expected %p, got %p",
                                     results_seen, want, got);
                    end
                end
                results_seen = results_seen + 1;
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_TRIGGER_THRESHOLD: threshold_q    = cfg_wdata;
                    CFG_BLINK_ON_AT:       blink_on_q     = cfg_wdata;
                    CFG_BLINK_PERIOD:      blink_period_q = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                recorder_results_due.push_back(advance_recorder(s_tdata[SAMPLE_W:0]));
        end
        words_pending = recorder_results_due.size();
    end

endmodule

FILE: tb/testbench.sv
// stimulus and verdict for the triggered transient recorder
module testbench;
    import ttr_pkg::*;

    localparam int AVG_LOG2      = AVG_LOG2_DEF;
    localparam int CAPTURE_DEPTH = CAPTURE_DEPTH_DEF;
    localparam int WIN           = 1 << AVG_LOG2;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
    localparam int REG_MAX       = (1 << REG_W) - 1;
    // highest window level that still leaves room for the spread and the remainder
    localparam int LEVEL_MAX     = SAMPLE_MAX - (WIN - 1);
    // words of the capture run; the test ends while the capture is still going
    localparam int CAPTURE_WORDS = 800;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PAD_W         = IN_TDATA_W - SAMPLE_W - 1;

    // index past the last register, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tlast;
    logic [PHASE_W-1:0]      m_tuser;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_addr  = '0;
    logic [REG_W-1:0]        cfg_wdata = '0;

    int                      mismatches;
    int                      words_pending;
    int                      cycle_count = 0;

    // no random idling on either side while set
    logic                    steady = 1'b0;
    // baseline the block should have settled on, and the threshold in force
    int                      base_lvl;
    int                      thr_now;

    triggered_transient_recorder #(
        .AVG_LOG2      (AVG_LOG2),
        .CAPTURE_DEPTH (CAPTURE_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    recorder_checker #(
        .AVG_LOG2      (AVG_LOG2),
        .CAPTURE_DEPTH (CAPTURE_DEPTH)
    ) scoreboard (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .words_pending (words_pending)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // result side back-pressure, about one stalled cycle in ten
    always @(posedge aclk) begin
        if (steady)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= 10);
    end

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one word on the sample stream, with an occasional gap in front of it
    task automatic send_word(input logic [SAMPLE_W-1:0] smp, input logic btn);
        if (!steady && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, btn, smp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // drop valid and wait until every result word is back
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (words_pending != 0);
    endtask

    // all three registers plus a write to the unused index; only while idle
    task automatic program_regs(input logic [REG_W-1:0] thr, input logic [REG_W-1:0] on_at,
                                input logic [REG_W-1:0] period);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_TRIGGER_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge aclk);
        cfg_addr  <= CFG_BLINK_ON_AT;
        cfg_wdata <= on_at;
        @(posedge aclk);
        cfg_addr  <= CFG_BLINK_PERIOD;
        cfg_wdata <= period;
        @(posedge aclk);
        cfg_addr  <= CFG_SPARE;
        cfg_wdata <= REG_W'($urandom_range(REG_MAX));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        thr_now = int'(thr);
    endtask

    // one full averaging window whose mean is exactly lvl, or a noisy window
    // that is kept only if its mean stays less than the threshold from the baseline
    task automatic send_window(input int lvl, input logic noisy, input logic press_first);
        logic [SAMPLE_W-1:0] smp [WIN];
        int                  sum;
        int                  dev;
        int                  spread;
        int                  d;
        sum = 0;
        dev = 0;
        if (noisy) begin
            for (int k = 0; k < WIN; k++) begin
                smp[k] = SAMPLE_W'($urandom_range(SAMPLE_MAX));
                sum    = sum + int'(smp[k]);
            end
            dev = (sum >> AVG_LOG2) - base_lvl;
            if (dev < 0) dev = -dev;
        end
        if (!noisy || dev >= thr_now) begin
            // pairs around lvl cancel, the remainder on word 0 is lost in the shift
            spread = (lvl < LEVEL_MAX - lvl) ? lvl : LEVEL_MAX - lvl;
            spread = $urandom_range(spread);
            for (int k = 0; k < WIN; k += 2) begin
                d          = $urandom_range(spread);
                smp[k]     = SAMPLE_W'(lvl + d);
                smp[k + 1] = SAMPLE_W'(lvl - d);
            end
            smp[0] = smp[0] + SAMPLE_W'($urandom_range(WIN - 1));
        end
        // button is only looked at on the first word; random elsewhere
        for (int k = 0; k < WIN; k++)
            send_word(smp[k], (k == 0) ? press_first : 1'($urandom_range(1)));
    endtask

    // armed windows that stay below the threshold, often right at its edge
    task automatic run_windows(input int count);
        int lim;
        int lo;
        int hi;
        int lvl;
        for (int w = 0; w < count; w++) begin
            lim = thr_now - 1;
            lo  = (base_lvl - lim < 0) ? 0 : base_lvl - lim;
            hi  = (base_lvl + lim > LEVEL_MAX) ? LEVEL_MAX : base_lvl + lim;
            case ($urandom_range(3))
                0:       lvl = lo;
                1:       lvl = hi;
                default: lvl = $urandom_range(hi, lo);
            endcase
            send_window(lvl, ($urandom_range(3) == 0), 1'b0);
        end
    endtask

    initial begin
        int                  base_sum;
        int                  v;
        int                  lvl;
        int                  tail;
        logic [SAMPLE_W-1:0] smp;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // baseline window: extremes and alternating bit patterns first,
        // button toggling although nothing looks at it yet
        base_sum = 0;
        for (int i = 0; i < WIN; i++) begin
            case (i)
                0:       smp = '0;
                1:       smp = SAMPLE_W'(SAMPLE_MAX);
                2:       smp = 10'h155;
                3:       smp = 10'h2AA;
                default: smp = SAMPLE_W'($urandom_range(SAMPLE_MAX));
            endcase
            base_sum = base_sum + int'(smp);
            send_word(smp, i[0]);
        end
        base_lvl = base_sum >> AVG_LOG2;

        // armed with the reset settings
        thr_now = THRESHOLD_RST;
        run_windows(4);

        // highest threshold, blink on and off at the same count
        settle();
        program_regs(REG_W'(REG_MAX), REG_W'(1), REG_W'(1));
        run_windows(3);

        // tightest threshold and the largest blink counts
        settle();
        program_regs(REG_W'(1), REG_W'(REG_MAX), REG_W'(REG_MAX));
        run_windows(2);

        // random settings with short blink cycles so the led moves
        repeat (4) begin
            settle();
            program_regs(REG_W'($urandom_range(REG_MAX, 1)), REG_W'($urandom_range(6, 1)),
                         REG_W'($urandom_range(8, 1)));
            run_windows($urandom_range(3, 2));
        end
        settle();

        // only one capture per reset: the seed picks how it is started
        if ($urandom_range(1)) begin
            // button held on the first word of a window, that word is captured
            send_word(SAMPLE_W'($urandom_range(SAMPLE_MAX)), 1'b1);
            tail = CAPTURE_WORDS - 1;
        end else begin
            // window mean exactly at the threshold, zero threshold included
            if ($urandom_range(1)) begin
                v   = 0;
                lvl = base_lvl;
            end else if ($urandom_range(1) && base_lvl >= 1) begin
                v   = $urandom_range(base_lvl, 1);
                lvl = base_lvl - v;
            end else begin
                v   = $urandom_range(LEVEL_MAX - base_lvl, 1);
                lvl = base_lvl + v;
            end
            program_regs(REG_W'(v), REG_W'($urandom_range(REG_MAX, 1)),
                         REG_W'($urandom_range(REG_MAX, 1)));
            send_window(lvl, 1'b0, 1'b0);
            tail = CAPTURE_WORDS;
        end

        // capture run; a long stretch in the middle runs without any idling
        for (int n = 0; n < tail; n++) begin
            if (n == 200) steady <= 1'b1;
            if (n == 600) steady <= 1'b0;
            send_word(SAMPLE_W'($urandom_range(SAMPLE_MAX)), 1'($urandom_range(1)));
        end

        settle();
        // results pass the input and result registers; leave room for strays
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && words_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
